### hdl/site_frequency_pattern_table_macros.svh
// assertion macros for the site pattern table
`ifndef SITE_FREQUENCY_PATTERN_TABLE_MACROS_SVH
`define SITE_FREQUENCY_PATTERN_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define SFPT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFPT_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SFPT_ASSERT(label, clk, rst, prop, msg)
`define SFPT_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### hdl/sfpt_pkg.sv
// shared types and constants of the site pattern table
package sfpt_pkg;
  localparam int MAX_PATTERNS = 1024;
  localparam int MAX_TAXA     = 256;
  localparam int ALPHABET     = 20;
  localparam int CODE_W   = 7;
  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int BIN_W    = $clog2(MAX_TAXA + 1);
  localparam int ROW_W    = BIN_W * ALPHABET;
  localparam int IDX_W    = 10;
  localparam int ADDR_W   = $clog2(MAX_PATTERNS);
  localparam int CNT_W    = $clog2(MAX_PATTERNS + 1);
  localparam int OCC_W    = 32;
  localparam int TAXA_W   = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_INS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept_en;
    logic start;
    logic rd;
    logic advance;
    logic hit_upd;
    logic insert;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic match;
    logic out_free;
  } stat_t;
endpackage

### hdl/sfpt_ctrl.sv
// controller state machine of the site pattern table
module sfpt_ctrl
  import sfpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_last) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = stat.at_end ? ST_INS : ST_CMP;
      end
      ST_CMP: begin
        state_next = stat.match ? ST_DONE : ST_RD;
      end
      ST_INS: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept_en = 1'b1;
        cmd.start     = in_valid && in_last;
      end
      ST_RD: begin
        cmd.rd = !stat.at_end;
      end
      ST_CMP: begin
        cmd.hit_upd = stat.match;
        cmd.advance = !stat.match;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end
endmodule

### hdl/sfpt_datapath.sv
// histogram, pattern memories and output register of the site pattern table
`include "site_frequency_pattern_table_macros.svh"
module sfpt_datapath
  import sfpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic                 in_valid,
  input  logic [CODE_W-1:0]    in_code,
  input  logic                 out_ready,
  output stat_t                stat,
  output logic                 out_valid,
  output logic [IDX_W-1:0]     out_idx,
  output logic                 out_new,
  output logic [OCC_W-1:0]     out_occ,
  output logic [TAXA_W-1:0]    out_taxa,
  output logic                 out_full
);
  logic [BIN_W-1:0]  hist [ALPHABET];
  logic [BIN_W-1:0]  col_taxa;
  logic [ROW_W-1:0]  hist_flat;
  logic [ROW_W-1:0]  row_mem [MAX_PATTERNS];
  logic [OCC_W-1:0]  occ_mem [MAX_PATTERNS];
  logic [ROW_W-1:0]  row_q;
  logic [OCC_W-1:0]  occ_q;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  total;
  logic              occ_we;
  logic [ADDR_W-1:0] occ_wa;
  logic [OCC_W-1:0]  occ_wd;
  logic [OCC_W-1:0]  occ_sat;
  logic              tbl_full;
  logic              res_new;
  logic              res_full;
  logic [IDX_W-1:0]  res_idx;
  logic [OCC_W-1:0]  res_occ;
  logic              count_it;

  always_comb begin
    for (int k = 0; k < ALPHABET; k++) begin
      hist_flat[k*BIN_W +: BIN_W] = hist[k];
    end
  end

  assign count_it = cmd.accept_en && in_valid && (in_code < CODE_W'(ALPHABET))
                    && (col_taxa < BIN_W'(MAX_TAXA));
  assign tbl_full = (total == CNT_W'(MAX_PATTERNS));
  assign occ_sat  = (occ_q == '1) ? occ_q : occ_q + OCC_W'(1);

  // histogram of the current column
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      for (int k = 0; k < ALPHABET; k++) hist[k] <= '0;
      col_taxa <= '0;
    end else if (count_it) begin
      hist[in_code[SYM_W-1:0]] <= hist[in_code[SYM_W-1:0]] + BIN_W'(1);
      col_taxa <= col_taxa + BIN_W'(1);
    end
  end

  // pattern table memories
  always_ff @(posedge clk) begin
    if (cmd.insert && !tbl_full) row_mem[total[ADDR_W-1:0]] <= hist_flat;
    if (cmd.rd) row_q <= row_mem[j[ADDR_W-1:0]];
  end

  always_comb begin
    occ_we = 1'b0;
    occ_wa = j[ADDR_W-1:0];
    occ_wd = occ_sat;
    if (cmd.hit_upd) begin
      occ_we = 1'b1;
    end else if (cmd.insert && !tbl_full) begin
      occ_we = 1'b1;
      occ_wa = total[ADDR_W-1:0];
      occ_wd = OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    if (cmd.rd) occ_q <= occ_mem[j[ADDR_W-1:0]];
  end

  // search index and table fill
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      j     <= '0;
    end else begin
      if (cmd.start) j <= '0;
      else if (cmd.advance) j <= j + CNT_W'(1);
      if (cmd.insert && !tbl_full) total <= total + CNT_W'(1);
    end
  end

  // result of the search
  always_ff @(posedge clk) begin
    if (rst) begin
      res_new  <= 1'b0;
      res_full <= 1'b0;
    end else if (cmd.hit_upd) begin
      res_new  <= 1'b0;
      res_full <= 1'b0;
    end else if (cmd.insert) begin
      res_new  <= !tbl_full;
      res_full <= tbl_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hit_upd) begin
      res_idx <= IDX_W'(j);
      res_occ <= occ_sat;
    end else if (cmd.insert) begin
      res_idx <= tbl_full ? '0 : IDX_W'(total);
      res_occ <= tbl_full ? '0 : OCC_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx  <= res_idx;
      out_new  <= res_new;
      out_occ  <= res_occ;
      out_taxa <= TAXA_W'(col_taxa);
      out_full <= res_full;
    end
  end

  assign stat.at_end   = (j == total);
  assign stat.match    = (row_q == hist_flat);
  assign stat.out_free = !out_valid || out_ready;

  `SFPT_ASSERT_NEVER(a_total_bound, clk, rst, total > CNT_W'(MAX_PATTERNS), "table overfilled")
  `SFPT_ASSERT(a_load_free, clk, rst, cmd.load_out |-> (!out_valid || out_ready), "result overwritten")
  `SFPT_ASSERT_NEVER(a_new_full, clk, rst, res_new && res_full, "new and full together")
  `SFPT_ASSERT(a_new_occ, clk, rst, (cmd.load_out && res_new) |=> (out_occ == OCC_W'(1)), "new pattern count not one")
endmodule

### hdl/site_frequency_pattern_table.sv
// top level of the site pattern table
// site pattern table: counts the residue codes of one alignment column,
// one taxon per input word, then looks the column histogram up in a table
// of distinct patterns and reports one result word per column
// input channel s_*: s_tdata[6:0] = char_code, s_tlast marks the last
//   taxon of the column; codes of 20 or more are ignored
// output channel m_*: one word per column, tdata holds pattern_index,
//   occurrences, taxa_counted; tuser holds is_new and table_full
// throughput: a non-last word is taken every cycle while idle (one histogram update)
// search at a column end: the stored patterns are read one at a time from
//   the pattern memory's single read port and compared in turn, so the wait
//   for the result grows with N = stored patterns (up to 1024)
// no input word is taken during the search; a waiting result sits in the
//   output register, and input words keep flowing while it waits
// a stalled receiver holds the next column's result back after its search,
//   and no input word is taken until the output register frees
// reset clears the histogram, the pattern count and the output valid;
//   the pattern memories need no clearing since only filled rows are read
module site_frequency_pattern_table
  import sfpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] char_code, [7] zero
  input  logic        s_tlast,   // last_in_site
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [9:0] pattern_index, [41:10] occurrences,
                                 // [50:42] taxa_counted, [55:51] zero
  output logic [1:0]  m_tuser    // [0] is_new, [1] table_full
);
  cmd_t  cmd;
  stat_t stat;
  logic [IDX_W-1:0]  out_idx;
  logic              out_new;
  logic [OCC_W-1:0]  out_occ;
  logic [TAXA_W-1:0] out_taxa;
  logic              out_full;

  sfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfpt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_valid  (s_tvalid),
    .in_code   (s_tdata[CODE_W-1:0]),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_idx   (out_idx),
    .out_new   (out_new),
    .out_occ   (out_occ),
    .out_taxa  (out_taxa),
    .out_full  (out_full)
  );

  // only the idle state takes words
  assign s_tready = cmd.accept_en;
  assign m_tdata  = {5'd0, out_taxa, out_occ, out_idx};
  assign m_tuser  = {out_full, out_new};
endmodule

### tb/tb_site_frequency_pattern_table.sv
// testbench for the site pattern table: column streams, table model, result checks
`timescale 1ns / 100ps

module tb_site_frequency_pattern_table;
  import sfpt_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  site_frequency_pattern_table uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // one taxon word as it goes into the block
  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } taxon_word_t;

  // one column result
  typedef struct {
    logic [IDX_W-1:0]  index;
    logic              fresh;
    logic [OCC_W-1:0]  occ;
    logic [TAXA_W-1:0] taxa;
    logic              full;
  } column_result_t;

  taxon_word_t    taxon_q[$];
  column_result_t column_results_q[$];

  // pattern table model
  logic [BIN_W-1:0] col_hist[ALPHABET];
  logic [BIN_W-1:0] stored_bins[MAX_PATTERNS][ALPHABET];
  logic [OCC_W-1:0] stored_occ[MAX_PATTERNS];
  int               stored_count;
  int               col_taxa;

  // columns kept for replay so that table hits happen often
  logic [CODE_W-1:0] kept_codes[256][8];
  int                kept_len[256];
  int                kept_n;

  int  errors;
  int  columns_seen;
  int  new_seen;
  int  hit_seen;
  int  full_seen;
  int  items_sent;
  bit  calm;  // stretch with no idling on the input side
  int  in_gap;
  int  out_gap;

  // update the model with one taxon word, queue the column result on a last word
  function automatic void model_taxon(logic [CODE_W-1:0] code, logic last);
    column_result_t r;
    bit             hit;
    hit = 0;
    if (code < ALPHABET && col_taxa < MAX_TAXA) begin
      col_hist[code] = col_hist[code] + 1;
      col_taxa++;
    end
    if (last) begin
      r = '{index: '0, fresh: 1'b0, occ: '0, taxa: col_taxa[TAXA_W-1:0], full: 1'b0};
      for (int j = 0; j < stored_count && !hit; j++) begin
        if (stored_bins[j] == col_hist) begin
          hit = 1;
          if (stored_occ[j] != '1) stored_occ[j] = stored_occ[j] + 1;
          r.index = j[IDX_W-1:0];
          r.occ   = stored_occ[j];
        end
      end
      if (!hit) begin
        if (stored_count < MAX_PATTERNS) begin
          stored_bins[stored_count] = col_hist;
          stored_occ[stored_count]  = 1;
          r.index = stored_count[IDX_W-1:0];
          r.occ   = 1;
          r.fresh = 1'b1;
          stored_count++;
        end else begin
          r.full = 1'b1;
        end
      end
      column_results_q.push_back(r);
      foreach (col_hist[k]) col_hist[k] = '0;
      col_taxa = 0;
    end
  endfunction

  function automatic void send_taxon(logic [CODE_W-1:0] code, logic last);
    taxon_q.push_back('{code: code, last: last});
    items_sent++;
    model_taxon(code, last);
  endfunction

  // a column of n random codes, some of them gap/unknown codes when noise is set
  function automatic void send_random_column(int n, bit noise);
    logic [CODE_W-1:0] c;
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 5) == 0) c = CODE_W'($urandom_range(ALPHABET, 127));
      else c = CODE_W'($urandom_range(0, ALPHABET - 1));
      if (i < 8) kept_codes[kept_n % 256][i] = c;
      send_taxon(c, i == n - 1);
    end
    if (n <= 8) begin
      kept_len[kept_n % 256] = n;
      kept_n++;
    end
  endfunction

  // replay one earlier column, its pattern is normally a hit
  function automatic void replay_column();
    int s;
    s = $urandom_range(0, (kept_n < 256 ? kept_n : 256) - 1);
    for (int i = 0; i < kept_len[s]; i++)
      send_taxon(kept_codes[s][i], i == kept_len[s] - 1);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // input driver: one word per handshake, random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
      in_gap   <= 0;
      calm     <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0 && !calm) begin
          s_tvalid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (taxon_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, taxon_q[0].code};
          s_tlast  <= taxon_q[0].last;
          void'(taxon_q.pop_front());
          in_gap   <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor: compare each result word with the oldest expected one
  always @(posedge clk) begin
    column_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
      out_gap  <= 0;
    end else begin
      if (out_gap > 0) begin
        m_tready <= 1'b0;
        out_gap  <= out_gap - 1;
      end else begin
        m_tready <= 1'b1;
        out_gap  <= pick_gap();
      end
      if (m_tvalid && m_tready) begin
        if (column_results_q.size() == 0) begin
          $error("result word with no column result expected");
          errors++;
        end else begin
          e = column_results_q.pop_front();
          columns_seen++;
          if (e.full) full_seen++;
          else if (e.fresh) new_seen++;
          else hit_seen++;
          if (m_tdata[9:0] !== e.index) begin
            $error("pattern_index expected %0d got %0d", e.index, m_tdata[9:0]);
            errors++;
          end
          if (m_tuser[0] !== e.fresh) begin
            $error("is_new expected %0d got %0d", e.fresh, m_tuser[0]);
            errors++;
          end
          if (m_tdata[41:10] !== e.occ) begin
            $error("occurrences expected %0d got %0d", e.occ, m_tdata[41:10]);
            errors++;
          end
          if (m_tdata[50:42] !== e.taxa) begin
            $error("taxa_counted expected %0d got %0d", e.taxa, m_tdata[50:42]);
            errors++;
          end
          if (m_tuser[1] !== e.full) begin
            $error("table_full expected %0d got %0d", e.full, m_tuser[1]);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    errors       = 0;
    columns_seen = 0;
    new_seen     = 0;
    hit_seen     = 0;
    full_seen    = 0;
    items_sent   = 0;
    stored_count = 0;
    col_taxa     = 0;
    kept_n       = 0;
    foreach (col_hist[k]) col_hist[k] = '0;

    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty column, extreme codes, ignored last word, a hit
    send_taxon(7'd127, 1'b1);
    send_taxon(7'd0, 1'b0);
    send_taxon(7'd19, 1'b1);
    send_taxon(7'd20, 1'b0);
    send_taxon(7'd0, 1'b0);
    send_taxon(7'd19, 1'b0);
    send_taxon(7'd85, 1'b1);
    send_taxon(7'd19, 1'b0);
    send_taxon(7'd0, 1'b1);
    send_taxon(7'd42, 1'b1);
    send_taxon(7'd7, 1'b0);
    send_taxon(7'd7, 1'b0);
    send_taxon(7'd13, 1'b1);
    // column overflow: counting stops at the taxa limit
    for (int i = 0; i < MAX_TAXA + 4; i++) send_taxon(7'd5, i == MAX_TAXA + 3);
    for (int i = 0; i < MAX_TAXA; i++) send_taxon(CODE_W'(i % ALPHABET), i == MAX_TAXA - 1);

    // random columns mixing new patterns, repeats and noise
    while (items_sent < 1550) begin
      if (kept_n > 0 && $urandom_range(0, 2) == 0) replay_column();
      else send_random_column($urandom_range(1, 6), 1'b1);
    end

    // longer columns against a well filled table, mixed with repeats
    for (int n = 0; n < 30; n++) begin
      if ($urandom_range(0, 1) == 0) replay_column();
      else send_random_column($urandom_range(6, 8), 1'b1);
    end

    while (taxon_q.size() > 0 || s_tvalid || column_results_q.size() > 0) @(posedge clk);
    repeat (2 * MAX_PATTERNS + 20) @(posedge clk);

    $display("columns checked: %0d (new %0d, hits %0d, rejected on full table %0d)",
             columns_seen, new_seen, hit_seen, full_seen);
    $display("patterns stored: %0d, including overflow and ignored-code columns",
             stored_count);
    if (errors == 0 && column_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
